// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

  // operation codes, anything above peek acts as peek
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK       = 3'd4;

  localparam logic signed [31:0] EMPTY_WORD = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
    logic               is_full;
    logic               refused;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic read;
  } ctl_t;

endpackage

// ===== hw/rtl/deq_ctrl.sv =====
module deq_ctrl
  import deq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output ctl_t ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_READ;
      ST_READ: state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_RESP);
  assign ctl.load = start && (state == ST_IDLE);
  assign ctl.exec = (state == ST_EXEC);
  assign ctl.read = (state == ST_READ);

endmodule

// ===== hw/rtl/deq_dpath.sv =====
module deq_dpath
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  ctl_t    ctl,
  input  cmd_t    cmd,
  output result_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic signed [31:0] mem [DEPTH];

  logic [2:0]         op_reg;
  logic signed [31:0] val_reg;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic               refused;
  logic signed [31:0] rd_front;
  logic signed [31:0] rd_back;

  logic          is_push, is_pop, q_full, q_empty, do_push, do_pop;
  logic [AW-1:0] head_dec, head_inc, tail_pos, back_pos, wr_addr;
  logic [SW-1:0] tail_sum, back_sum;
  logic [CW-1:0] back_off;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count_next;

  always_comb begin
    is_push  = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_PUSH_BACK);
    is_pop   = (op_reg == OP_POP_FRONT) || (op_reg == OP_POP_BACK);
    q_full   = (count == DEPTH_C);
    q_empty  = (count == '0);
    do_push  = is_push && !q_full;
    do_pop   = is_pop && !q_empty;
    head_dec = (head == '0) ? LAST_A : head - AW'(1);
    head_inc = (head == LAST_A) ? '0 : head + AW'(1);
    // slot just past the back, wrapped
    tail_sum = SW'(head) + SW'(count);
    if (tail_sum >= DEPTH_S) tail_sum = tail_sum - DEPTH_S;
    tail_pos = tail_sum[AW-1:0];
    wr_addr  = (op_reg == OP_PUSH_FRONT) ? head_dec : tail_pos;
    // back slot for the read phase
    back_off = q_empty ? '0 : count - CW'(1);
    back_sum = SW'(head) + SW'(back_off);
    if (back_sum >= DEPTH_S) back_sum = back_sum - DEPTH_S;
    back_pos = back_sum[AW-1:0];

    head_next  = head;
    count_next = count;
    if (do_push) begin
      count_next = count + CW'(1);
      if (op_reg == OP_PUSH_FRONT) head_next = head_dec;
    end else if (do_pop) begin
      count_next = count - CW'(1);
      if (op_reg == OP_POP_FRONT) head_next = head_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_reg  <= cmd.opcode;
      val_reg <= cmd.push_value;
    end
    if (ctl.exec) begin
      refused <= (is_push && q_full) || (is_pop && q_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && do_push) mem[wr_addr] <= val_reg;
    if (ctl.read) begin
      rd_front <= mem[head];
      rd_back  <= mem[back_pos];
    end
  end

  always_comb begin
    result.front_value = q_empty ? EMPTY_WORD : rd_front;
    result.back_value  = q_empty ? EMPTY_WORD : rd_back;
    result.is_empty    = q_empty;
    result.is_full     = q_full;
    result.refused     = refused;
  end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// double-ended queue of signed 32-bit words in a DEPTH-entry ring memory
// result: strobed on done after the execute and read states that follow the edge that takes the beat
// a new operation is taken only while idle, once the execute / read / respond
//   sequence around the single-write, dual-read ring memory is through
// reset: synchronous rst empties the queue (head and count to zero), no memory sweep
// the receiver cannot stall: each result shows for exactly one cycle with done
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  // sequencing commands from controller to datapath
  ctl_t ctl;

  // controller: idle, execute (move head/count, write entry),
  // read (fetch front and back words), respond (strobe done)
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // datapath: ring memory, head index, word count, refusal flag
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cmd    (cmd),
    .result (result)
  );

endmodule

// ===== hw/rtl/deq_checker.sv =====
module deq_checker
  import deq_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // a taken beat makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after beat");

  // every taken beat gets its result once the execute and read states have passed
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result missing");

  // done is a single-cycle strobe and frees the block
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not a single pulse");

  // an empty queue reports all-ones words and is not full
  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |->
      (result.front_value == EMPTY_WORD && result.back_value == EMPTY_WORD
       && !result.is_full))
    else $error("empty result inconsistent");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== tb/sv/deq_tracker_pkg.sv =====
`timescale 1ns / 1ps

package deq_tracker_pkg;
  import deq_pkg::*;

  localparam int RING_DEPTH = 16;

  class deque_tracker;
    logic signed [31:0] ring_words [RING_DEPTH];
    int unsigned        head_pos;
    int unsigned        word_total;
    result_t            expected_results [$];
    int unsigned        mismatches;

    function new();
      head_pos   = 0;
      word_total = 0;
      mismatches = 0;
    endfunction

    // apply one accepted command beat and queue the state it should leave
    function void note_cmd(cmd_t c);
      result_t r;
      r = '0;
      case (c.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (word_total == RING_DEPTH) begin
            r.refused = 1'b1;
          end else if (c.opcode == OP_PUSH_FRONT) begin
            head_pos = (head_pos == 0) ? RING_DEPTH - 1 : head_pos - 1;
            ring_words[head_pos] = c.push_value;
            word_total++;
          end else begin
            ring_words[(head_pos + word_total) % RING_DEPTH] = c.push_value;
            word_total++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (word_total == 0) begin
            r.refused = 1'b1;
          end else begin
            if (c.opcode == OP_POP_FRONT) head_pos = (head_pos + 1) % RING_DEPTH;
            word_total--;
          end
        end
        default: ;  // peek and unused codes leave the state alone
      endcase
      if (word_total == 0) begin
        r.front_value = EMPTY_WORD;
        r.back_value  = EMPTY_WORD;
      end else begin
        r.front_value = ring_words[head_pos];
        r.back_value  = ring_words[(head_pos + word_total - 1) % RING_DEPTH];
      end
      r.is_empty = (word_total == 0);
      r.is_full  = (word_total == RING_DEPTH);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        mismatches++;
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      if (got.front_value !== want.front_value) begin
        $error("front_value: expected %0d, actual %0d", want.front_value, got.front_value);
        mismatches++;
      end
      if (got.back_value !== want.back_value) begin
        $error("back_value: expected %0d, actual %0d", want.back_value, got.back_value);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, actual %0b", want.is_empty, got.is_empty);
        mismatches++;
      end
      if (got.is_full !== want.is_full) begin
        $error("is_full: expected %0b, actual %0b", want.is_full, got.is_full);
        mismatches++;
      end
      if (got.refused !== want.refused) begin
        $error("refused: expected %0b, actual %0b", want.refused, got.refused);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void close_out();
      if (expected_results.size() != 0) begin
        $error("%0d results never arrived", expected_results.size());
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;
  import deq_tracker_pkg::*;

  localparam int N_RANDOM    = 1400;
  localparam int CALM_TAIL   = 200;     // last beats go back to back
  localparam int CYCLE_LIMIT = 200000;  // ~1430 beats plus sender gaps, with lots of slack
  localparam int DRAIN_WAIT  = 8;       // result shows after the execute and read states that follow the taking edge

  logic    clk;
  logic    rst;
  logic    start;
  cmd_t    cmd;
  logic    busy;
  logic    done;
  result_t result;

  deque_tracker tracker;
  int unsigned  cycle_count;

  double_ended_queue #(.DEPTH(RING_DEPTH)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // monitor: values read here are the ones that stood before the edge,
  // so a command beat is taken when start was high and busy low
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_cmd(cmd);
      if (done) tracker.check_result(result);
    end
  end

  // hold one command until the block takes it; start stays high afterwards
  task automatic send_cmd(input logic [2:0] op, input logic signed [31:0] value);
    start <= 1'b1;
    cmd   <= '{opcode: op, push_value: value};
    do @(posedge clk); while (busy);
  endtask

  // sender gap with start low
  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    cmd   <= '{opcode: 3'($urandom), push_value: $urandom};  // junk while idle
    repeat (n) @(posedge clk);
  endtask

  // wait until every queued expectation has been answered
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // mostly full-range words, with the corner values mixed in
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned push_bias;
    int unsigned roll;
    logic [2:0]  op;

    tracker = new();
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-queue corners, unused codes, extreme words
    send_cmd(OP_PEEK, 32'sd0);
    send_cmd(OP_POP_FRONT, 32'sd0);
    send_cmd(OP_POP_BACK, -32'sd1);
    send_cmd(3'd5, 32'sd12345);
    send_cmd(3'd7, 32'sh7FFF_FFFF);
    send_cmd(OP_PUSH_FRONT, 32'sh8000_0000);
    send_cmd(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_cmd(OP_POP_FRONT, 32'sd0);
    send_cmd(OP_POP_BACK, 32'sd0);
    // fill from both ends so the head wraps below zero, then push on full
    for (int k = 0; k < RING_DEPTH; k++) begin
      send_cmd((k % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
    end
    send_cmd(OP_PUSH_BACK, 32'sd1);
    send_cmd(OP_PUSH_FRONT, 32'sd2);

    // pause until the directed beats are all answered
    drain();

    // random: phases leaning toward pushes or pops walk the fill level
    // between empty and full, so both refusals and head wrap show up often
    push_bias = 50;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 4))
          0:       push_bias = 85;
          1:       push_bias = 15;
          2:       push_bias = 70;
          3:       push_bias = 30;
          default: push_bias = 50;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) op = 3'($urandom_range(4, 7));
      else if ($urandom_range(0, 99) < push_bias) op = OP_PUSH_FRONT + 3'($urandom_range(0, 1));
      else op = OP_POP_FRONT + 3'($urandom_range(0, 1));

      send_cmd(op, pick_word());

      // one more full stop halfway through
      if (i == N_RANDOM / 2) drain();
      else if (i < N_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 12));
    end

    // wind down: stop sending, let the last results come out
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    tracker.close_out();

    if (tracker.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
